// ===== sv/uvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the UV sphere vertex generator.
// No dependencies; every other file of the block imports it.
package uvs_pkg;

	// Grid and result field widths
	localparam int COORD_W = 9;
	localparam int POS_W   = 16;
	localparam int TEX_W   = 16;
	localparam int IDX_W   = 17;
	localparam int RAD_W   = 16;
	localparam int CFG_W   = 16;

	// Default grid limits and register reset values
	localparam int MAX_SECTORS_DEF = 256;
	localparam int MAX_STACKS_DEF  = 256;
	localparam logic [RAD_W-1:0]   RADIUS_RST  = 16'd256;
	localparam logic [COORD_W-1:0] SECTORS_RST = 9'd36;
	localparam logic [COORD_W-1:0] STACKS_RST  = 9'd18;

	// Phase is 2^24 units per turn, sine magnitudes are Q1.29
	localparam int PHASE_W = 24;
	localparam logic [PHASE_W-1:0] QUARTER = 24'h40_0000;
	localparam int SIN_W = 30;
	localparam logic [SIN_W-1:0] Q29_ONE = 30'h2000_0000;
	localparam logic [30:0] PI_Q29 = 31'h6487_ED51;

	// Long division: quotient bits per grid coordinate, tap for texture
	localparam int DIV_STEPS = 25;
	localparam int TEX_TAP   = 15;

	// Stages of one sine evaluation
	localparam int SINE_STAGES = 10;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_RADIUS  = 2'd0,
		REG_SECTORS = 2'd1,
		REG_STACKS  = 2'd2
	} cfg_reg_t;

	// Input word: one grid point
	typedef struct packed {
		logic [COORD_W-1:0] stack_row;
		logic [COORD_W-1:0] sector_col;
	} pt_t;

	// Output word: one vertex
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic                    parity;
		logic                    in_range;
		logic                    cell_valid;
		logic [IDX_W-1:0]        corner_first;
		logic [IDX_W-1:0]        corner_second;
		logic [IDX_W-1:0]        corner_first_next;
		logic [IDX_W-1:0]        corner_second_next;
	} vtx_t;

endpackage

// ===== sv/uv_sphere_vertex_generator.sv =====
`timescale 1ns / 1ps
// UV sphere vertex generator: takes grid point words and returns one vertex word for
// each accepted word: position, texture ratio, parity and cell corners.
// Throughput is one word per cycle while the output is not stalled; the pipeline is the
// input register, the 25-step long division of the grid coordinates, two rounding
// stages, the 10-stage sine series and three scaling stages.
// Each stage moves on when it is empty or its successor moves, so bubbles close up and
// new words are taken while a finished vertex waits. The user must write configuration
// only while no word is in flight; the block does not enforce it. No clearing pass is
// needed after reset. Depends on uvs_pkg, uvs_div and uvs_sine.
module uv_sphere_vertex_generator #(
	parameter int MAX_SECTORS = uvs_pkg::MAX_SECTORS_DEF,
	parameter int MAX_STACKS  = uvs_pkg::MAX_STACKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [uvs_pkg::CFG_W-1:0] cfg_data,
	input  logic                  pt_valid,
	output logic                  pt_ready,
	input  uvs_pkg::pt_t          pt,
	output logic                  vtx_valid,
	input  logic                  vtx_ready,
	output uvs_pkg::vtx_t         vtx
);
	import uvs_pkg::*;

	localparam int SW  = $clog2(MAX_SECTORS + 1);
	localparam int TW  = $clog2(MAX_STACKS + 1);
	localparam int RWS = (COORD_W > SW) ? COORD_W : SW;
	localparam int RWT = (COORD_W > TW) ? COORD_W : TW;

	// Stage numbers
	localparam int ST_DIV  = 1;
	localparam int ST_RND  = ST_DIV + DIV_STEPS;
	localparam int ST_PH   = ST_RND + 1;
	localparam int ST_SIN  = ST_PH + 1;
	localparam int ST_SCL  = ST_SIN + SINE_STAGES;
	localparam int ST_MUL  = ST_SCL + 1;
	localparam int ST_OUT  = ST_MUL + 1;
	localparam int NST     = ST_OUT + 1;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               in_range;
		logic               cell_valid;
		logic               parity;
		logic [IDX_W-1:0]   c_first;
		logic [IDX_W-1:0]   c_second;
		logic [IDX_W-1:0]   c_first_next;
		logic [IDX_W-1:0]   c_second_next;
		logic [TEX_W-1:0]   tex_u;
		logic [TEX_W-1:0]   tex_v;
	} side_t;

	function automatic logic [SW-1:0] sec_eff(input logic [COORD_W-1:0] c);
		if (c == '0) return SW'(1);
		if (32'(c) > MAX_SECTORS) return SW'(MAX_SECTORS);
		return SW'(c);
	endfunction

	function automatic logic [TW-1:0] stk_eff(input logic [COORD_W-1:0] c);
		if (c == '0) return TW'(1);
		if (32'(c) > MAX_STACKS) return TW'(MAX_STACKS);
		return TW'(c);
	endfunction

	function automatic logic signed [POS_W-1:0] to_q88(input logic [16:0] m,
			input logic neg);
		logic [16:0] lim;
		if (neg) begin
			lim = (m > 17'd32768) ? 17'd32768 : m;
			return POS_W'(17'h1_0000 - lim);
		end
		return (m > 17'd32767) ? 16'sd32767 : POS_W'(m);
	endfunction

	logic [RAD_W-1:0] radius_q;
	logic [SW-1:0]    sec_eff_q;
	logic [TW-1:0]    stk_eff_q;
	logic [SW-1:0]    thr_sec;
	logic [TW-1:0]    thr_stk;

	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;
	side_t          side_s [NST];
	side_t          side_d [NST];

	logic [DIV_STEPS-1:0] col_quot, row_quot;
	logic [RWS-1:0]       col_rem;
	logic [RWT-1:0]       row_rem;
	logic [TEX_W-1:0]     col_tex, row_tex;

	logic [PHASE_W-1:0] sec_ph_s26, sec_ph_s27, stk_ph_s27;
	logic [PHASE_W-1:0] stk_q_s26;
	logic [RWT-1:0]     stk_r_s26;
	logic [RWT:0]       stk_rsum;

	logic [SIN_W-1:0] sst_mag, cst_mag, ssc_mag, csc_mag;
	logic             sst_neg, cst_neg, ssc_neg, csc_neg;

	logic [46:0] xy_sum, mz_sum;
	logic [24:0] xy_s38;
	logic [16:0] mz_s38, mz_s39;
	logic [SIN_W-1:0] csc_s38, ssc_s38;
	logic nx_s38, ny_s38, nz_s38, nx_s39, ny_s39, nz_s39;
	logic [55:0] mx_sum, my_sum;
	logic [16:0] mx_s39, my_s39;
	vtx_t vtx_d;
	vtx_t vtx_s40;

	// Configuration writes; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			sec_eff_q <= sec_eff(SECTORS_RST);
			stk_eff_q <= stk_eff(STACKS_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIUS:  radius_q  <= cfg_data;
				REG_SECTORS: sec_eff_q <= sec_eff(cfg_data[COORD_W-1:0]);
				REG_STACKS:  stk_eff_q <= stk_eff(cfg_data[COORD_W-1:0]);
				default: ;
			endcase
		end
	end

	assign thr_sec = sec_eff_q - (sec_eff_q >> 1);
	assign thr_stk = stk_eff_q - (stk_eff_q >> 1);

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en[NST-1] = !vld_s[NST-1] || vtx_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end
	assign pt_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= pt_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Side data: grid flags, corners and texture ratios travel with the word
	always_comb begin
		side_d[0]            = '0;
		side_d[0].row        = pt.stack_row;
		side_d[0].col        = pt.sector_col;
		side_d[0].in_range   = (32'(pt.stack_row) <= 32'(stk_eff_q))
			&& (32'(pt.sector_col) <= 32'(sec_eff_q));
		side_d[0].cell_valid = (32'(pt.stack_row) < 32'(stk_eff_q))
			&& (32'(pt.sector_col) < 32'(sec_eff_q));
		side_d[0].parity     = pt.stack_row[0] ^ pt.sector_col[0];
		for (int k = 1; k < NST; k++) begin
			side_d[k] = side_s[k-1];
		end
		side_d[1].c_first = IDX_W'(side_s[0].row) * (IDX_W'(sec_eff_q) + IDX_W'(1))
			+ IDX_W'(side_s[0].col);
		side_d[2].c_second      = IDX_W'(side_s[1].c_first + sec_eff_q + 1'b1);
		side_d[2].c_first_next  = IDX_W'(side_s[1].c_first + 1'b1);
		side_d[2].c_second_next = IDX_W'(side_s[1].c_first + sec_eff_q + 2'd2);
		side_d[ST_RND].tex_u    = col_tex;
		side_d[ST_RND].tex_v    = row_tex;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NST; k++) begin
			if (en[k]) side_s[k] <= side_d[k];
		end
	end

	// Grid coordinate over count, one quotient bit per stage
	uvs_div #(.NW(COORD_W), .DW(SW)) u_div_col (
		.clk  (clk),
		.en   (en[ST_DIV +: DIV_STEPS]),
		.num  (side_s[0].col),
		.den  (sec_eff_q),
		.quot (col_quot),
		.rem  (col_rem),
		.tex  (col_tex)
	);

	uvs_div #(.NW(COORD_W), .DW(TW)) u_div_row (
		.clk  (clk),
		.en   (en[ST_DIV +: DIV_STEPS]),
		.num  (side_s[0].row),
		.den  (stk_eff_q),
		.quot (row_quot),
		.rem  (row_rem),
		.tex  (row_tex)
	);

	// Round the phases; the stack phase needs one quotient bit less
	assign stk_rsum = (RWT+1)'(row_rem) + (row_quot[0] ? (RWT+1)'(stk_eff_q) : '0);
	always_ff @(posedge clk) begin
		if (en[ST_RND]) begin
			sec_ph_s26 <= PHASE_W'(col_quot + DIV_STEPS'(col_rem >= RWS'(thr_sec)));
			stk_q_s26  <= row_quot[DIV_STEPS-1:1];
			stk_r_s26  <= stk_rsum[RWT:1];
		end
		if (en[ST_PH]) begin
			sec_ph_s27 <= sec_ph_s26;
			stk_ph_s27 <= QUARTER - (stk_q_s26 + PHASE_W'(stk_r_s26 >= RWT'(thr_stk)));
		end
	end

	// Sine and cosine of both angles
	uvs_sine u_sin_stk (
		.clk (clk), .en (en[ST_SIN +: SINE_STAGES]),
		.phase (stk_ph_s27), .mag (sst_mag), .neg (sst_neg)
	);
	uvs_sine u_cos_stk (
		.clk (clk), .en (en[ST_SIN +: SINE_STAGES]),
		.phase (stk_ph_s27 + QUARTER), .mag (cst_mag), .neg (cst_neg)
	);
	uvs_sine u_sin_sec (
		.clk (clk), .en (en[ST_SIN +: SINE_STAGES]),
		.phase (sec_ph_s27), .mag (ssc_mag), .neg (ssc_neg)
	);
	uvs_sine u_cos_sec (
		.clk (clk), .en (en[ST_SIN +: SINE_STAGES]),
		.phase (sec_ph_s27 + QUARTER), .mag (csc_mag), .neg (csc_neg)
	);

	// Scale by radius, then by the sector terms
	assign xy_sum = 47'(radius_q) * 47'(cst_mag) + (47'd1 << 20);
	assign mz_sum = 47'(radius_q) * 47'(sst_mag) + (47'd1 << 28);
	assign mx_sum = 56'(xy_s38) * 56'(csc_s38) + (56'd1 << 36);
	assign my_sum = 56'(xy_s38) * 56'(ssc_s38) + (56'd1 << 36);

	always_ff @(posedge clk) begin
		if (en[ST_SCL]) begin
			xy_s38  <= xy_sum[45:21];
			mz_s38  <= mz_sum[45:29];
			csc_s38 <= csc_mag;
			ssc_s38 <= ssc_mag;
			nx_s38  <= cst_neg ^ csc_neg;
			ny_s38  <= cst_neg ^ ssc_neg;
			nz_s38  <= sst_neg;
		end
		if (en[ST_MUL]) begin
			mx_s39 <= mx_sum[53:37];
			my_s39 <= my_sum[53:37];
			mz_s39 <= mz_s38;
			nx_s39 <= nx_s38;
			ny_s39 <= ny_s38;
			nz_s39 <= nz_s38;
		end
	end

	// Output word: saturate, zero what the grid flags rule out
	always_comb begin
		vtx_d = '0;
		if (side_s[ST_MUL].in_range) begin
			vtx_d.pos_x    = to_q88(mx_s39, nx_s39 && (mx_s39 != '0));
			vtx_d.pos_y    = to_q88(my_s39, ny_s39 && (my_s39 != '0));
			vtx_d.pos_z    = to_q88(mz_s39, nz_s39 && (mz_s39 != '0));
			vtx_d.tex_u    = side_s[ST_MUL].tex_u;
			vtx_d.tex_v    = side_s[ST_MUL].tex_v;
			vtx_d.parity   = side_s[ST_MUL].parity;
			vtx_d.in_range = 1'b1;
		end
		if (side_s[ST_MUL].cell_valid) begin
			vtx_d.cell_valid         = 1'b1;
			vtx_d.corner_first       = side_s[ST_MUL].c_first;
			vtx_d.corner_second      = side_s[ST_MUL].c_second;
			vtx_d.corner_first_next  = side_s[ST_MUL].c_first_next;
			vtx_d.corner_second_next = side_s[ST_MUL].c_second_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			vtx_s40 <= vtx_d;
		end
	end

	assign vtx       = vtx_s40;
	assign vtx_valid = vld_s[NST-1];

	// An accepted word occupies the first stage next cycle
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready |=> vld_s[0])
		else $error("accepted word did not enter the pipeline");

	// Input backs up only behind a full pipeline and a stalled output
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pt_ready |-> (&vld_s) && !vtx_ready)
		else $error("input stalled with room in the pipeline");

	// A valid cell lies on the grid
	a_cell_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx.cell_valid |-> vtx.in_range)
		else $error("cell flagged valid outside the grid");

	// A written count never takes effect as zero
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && (cfg_index == REG_SECTORS || cfg_index == REG_STACKS)
		|=> sec_eff_q != '0 && stk_eff_q != '0)
		else $error("effective count is zero");

endmodule

// ===== sv/uvs_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: num * 2^k / den, one quotient bit per stage.
// Also yields the rounded Q1.15 ratio tapped partway. Depends on uvs_pkg.
module uvs_div #(
	parameter int NW = 9,
	parameter int DW = 9,
	localparam int RW = (NW > DW) ? NW : DW
) (
	input  logic                         clk,
	input  logic [uvs_pkg::DIV_STEPS-1:0] en,
	input  logic [NW-1:0]                num,
	input  logic [DW-1:0]                den,
	output logic [uvs_pkg::DIV_STEPS-1:0] quot,
	output logic [RW-1:0]                rem,
	output logic [uvs_pkg::TEX_W-1:0]    tex
);
	import uvs_pkg::*;

	logic [RW-1:0]        r_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s [DIV_STEPS];
	logic [TEX_W-1:0]     tex_s [TEX_TAP+1:DIV_STEPS-1];
	logic [DW-1:0]        thr;

	// Round up when the remainder reaches half the divisor
	assign thr = den - (den >> 1);

	genvar j;
	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_step
			logic [RW:0]          trial;
			logic [DIV_STEPS-1:0] q_prev;
			logic                 take;

			if (j == 0) begin : g_first
				assign trial  = (RW+1)'(num);
				assign q_prev = '0;
			end else begin : g_next
				assign trial  = {r_s[j-1], 1'b0};
				assign q_prev = q_s[j-1];
			end

			// Subtract the divisor where it fits, shift in the quotient bit
			assign take = trial >= (RW+1)'(den);
			always_ff @(posedge clk) begin
				if (en[j]) begin
					r_s[j] <= RW'(take ? trial - (RW+1)'(den) : trial);
					q_s[j] <= {q_prev[DIV_STEPS-2:0], take};
				end
			end

			// Round the texture ratio at the tap, then carry it along
			if (j == TEX_TAP + 1) begin : g_tap
				always_ff @(posedge clk) begin
					if (en[j]) begin
						tex_s[j] <= q_s[j-1][TEX_W-1:0] + TEX_W'(r_s[j-1] >= RW'(thr));
					end
				end
			end else if (j > TEX_TAP + 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en[j]) begin
						tex_s[j] <= tex_s[j-1];
					end
				end
			end
		end
	endgenerate

	assign quot = q_s[DIV_STEPS-1];
	assign rem  = r_s[DIV_STEPS-1];
	assign tex  = tex_s[DIV_STEPS-1];

endmodule

// ===== sv/uvs_sine.sv =====
`timescale 1ns / 1ps
// Ten-stage sine of a 24-bit phase: quarter-wave fold, then a Horner series.
// Magnitude in Q1.29 with a separate sign. Depends on uvs_pkg.
module uvs_sine (
	input  logic                           clk,
	input  logic [uvs_pkg::SINE_STAGES-1:0] en,
	input  logic [uvs_pkg::PHASE_W-1:0]    phase,
	output logic [uvs_pkg::SIN_W-1:0]      mag,
	output logic                           neg
);
	import uvs_pkg::*;

	// Exact division by a constant for dividends below 2^31
	localparam int K72 = 38;
	localparam int K42 = 37;
	localparam int K20 = 36;
	localparam int K6  = 34;
	localparam logic [63:0] M72 = ((64'd1 << K72) + 64'd71) / 64'd72;
	localparam logic [63:0] M42 = ((64'd1 << K42) + 64'd41) / 64'd42;
	localparam logic [63:0] M20 = ((64'd1 << K20) + 64'd19) / 64'd20;
	localparam logic [63:0] M6  = ((64'd1 << K6) + 64'd5) / 64'd6;

	function automatic logic [SIN_W-1:0] step_term(input logic [30:0] n,
			input logic [31:0] m, input int k);
		logic [62:0] prod;
		prod = 63'(n) * 63'(m);
		return Q29_ONE - SIN_W'(prod >> k);
	endfunction

	function automatic logic [30:0] mul_q29(input logic [30:0] a,
			input logic [SIN_W-1:0] b);
		logic [60:0] prod;
		prod = 61'(a) * 61'(b);
		return prod[59:29];
	endfunction

	logic [22:0]      fold;
	logic [53:0]      x_prod;
	logic [59:0]      x_sq;
	logic [58:0]      s_prod;
	logic [SIN_W-1:0] s_raw;
	logic [SIN_W-1:0] s_clamp;

	logic [29:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5, x2_s6, x2_s7;
	logic [30:0] n_s4, n_s6, n_s8;
	logic [SIN_W-1:0] t_s3, t_s5, t_s7, t_s9, mag_s10;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic neg_s10;

	// Fold the phase into the first quadrant and scale to radians
	assign fold   = phase[PHASE_W-2] ? (23'h40_0000 - {1'b0, phase[PHASE_W-3:0]})
		: {1'b0, phase[PHASE_W-3:0]};
	assign x_prod = 54'(fold) * 54'(PI_Q29);
	assign x_sq   = 60'(x_s1) * 60'(x_s1);

	// Final product and clamp to one
	assign s_prod  = 59'(x_s9) * 59'(t_s9);
	assign s_raw   = s_prod[58:29];
	assign s_clamp = (s_raw > Q29_ONE) ? Q29_ONE : s_raw;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= x_prod[52:23];
			neg_s1 <= phase[PHASE_W-1];
		end
		if (en[1]) begin
			x_s2   <= x_s1;
			x2_s2  <= x_sq[59:29];
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			t_s3   <= step_term(x2_s2, M72[31:0], K72);
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			x_s4   <= x_s3;
			x2_s4  <= x2_s3;
			n_s4   <= mul_q29(x2_s3, t_s3);
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			x_s5   <= x_s4;
			x2_s5  <= x2_s4;
			t_s5   <= step_term(n_s4, M42[31:0], K42);
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			x_s6   <= x_s5;
			x2_s6  <= x2_s5;
			n_s6   <= mul_q29(x2_s5, t_s5);
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			x_s7   <= x_s6;
			x2_s7  <= x2_s6;
			t_s7   <= step_term(n_s6, M20[31:0], K20);
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			x_s8   <= x_s7;
			n_s8   <= mul_q29(x2_s7, t_s7);
			neg_s8 <= neg_s7;
		end
		if (en[8]) begin
			x_s9   <= x_s8;
			t_s9   <= step_term(n_s8, M6[31:0], K6);
			neg_s9 <= neg_s8;
		end
		if (en[9]) begin
			mag_s10 <= s_clamp;
			neg_s10 <= neg_s9 && (s_clamp != '0);
		end
	end

	assign mag = mag_s10;
	assign neg = neg_s10;

endmodule

// ===== tb/uv_sphere_vertex_generator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the UV sphere vertex generator: grid point words in, vertex words out.
// Predicts each vertex with its own fixed-point sine and scaling. Depends on uvs_pkg and the DUT.
module uv_sphere_vertex_generator_tb;
	import uvs_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic pt_valid;
	logic pt_ready;
	pt_t pt;
	logic vtx_valid;
	logic vtx_ready;
	vtx_t vtx;

	// Settings held by the predictor
	logic [15:0] radius_q;
	logic [8:0] sectors_q;
	logic [8:0] stacks_q;

	vtx_t vertex_queue[$];
	int pt_idle_pct;
	int vtx_idle_pct;
	int errors;
	longint cycle_count;

	uv_sphere_vertex_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Quarter-wave sine of a 2^24-unit phase; magnitude in Q1.29, sign apart
	function automatic logic [63:0] turn_sine(input logic [23:0] ph, output logic neg);
		logic [1:0] quad;
		logic [63:0] r, x, x2, t;
		quad = ph[23:22];
		r = {42'd0, ph[21:0]};
		if (quad[0])
			r = 64'h40_0000 - r;
		x = (r * 64'h6487_ED51) >> 23;
		x2 = (x * x) >> 29;
		t = 64'h2000_0000;
		t = 64'h2000_0000 - ((x2 * t) >> 29) / 72;
		t = 64'h2000_0000 - ((x2 * t) >> 29) / 42;
		t = 64'h2000_0000 - ((x2 * t) >> 29) / 20;
		t = 64'h2000_0000 - ((x2 * t) >> 29) / 6;
		t = (x * t) >> 29;
		if (t > 64'h2000_0000)
			t = 64'h2000_0000;
		neg = quad[1] && t != 0;
		return t;
	endfunction

	function automatic logic [15:0] sat_q88(input logic [63:0] mag, input logic neg);
		if (neg) begin
			if (mag > 32768)
				mag = 32768;
			return 16'(65536 - mag);
		end
		if (mag > 32767)
			mag = 32767;
		return mag[15:0];
	endfunction

	function automatic vtx_t vertex_of(input pt_t p);
		vtx_t v;
		logic [63:0] s, t, row, col, sec_ph, stk_ph, cst, sst, csc, ssc, xy, mx, my, mz, first;
		logic ncst, nsst, ncsc, nssc;
		v = '0;
		s = (sectors_q == 0) ? 1 : (sectors_q > 256) ? 256 : sectors_q;
		t = (stacks_q == 0) ? 1 : (stacks_q > 256) ? 256 : stacks_q;
		row = p.stack_row;
		col = p.sector_col;
		if (row > t || col > s)
			return v;
		sec_ph = (((col << 24) + s / 2) / s) & 64'hFF_FFFF;
		stk_ph = (64'h40_0000 - (((row << 23) + t / 2) / t)) & 64'hFF_FFFF;
		sst = turn_sine(stk_ph[23:0], nsst);
		cst = turn_sine(24'(stk_ph + 64'h40_0000), ncst);
		ssc = turn_sine(sec_ph[23:0], nssc);
		csc = turn_sine(24'(sec_ph + 64'h40_0000), ncsc);
		xy = (radius_q * cst + (64'd1 << 20)) >> 21;
		mx = (xy * csc + (64'd1 << 36)) >> 37;
		my = (xy * ssc + (64'd1 << 36)) >> 37;
		mz = (radius_q * sst + (64'd1 << 28)) >> 29;
		v.pos_x = sat_q88(mx, (ncst ^ ncsc) && mx != 0);
		v.pos_y = sat_q88(my, (ncst ^ nssc) && my != 0);
		v.pos_z = sat_q88(mz, nsst && mz != 0);
		v.tex_u = 16'(((col << 15) + s / 2) / s);
		v.tex_v = 16'(((row << 15) + t / 2) / t);
		v.parity = row[0] ^ col[0];
		v.in_range = 1'b1;
		if (row < t && col < s) begin
			first = row * (s + 1) + col;
			v.cell_valid = 1'b1;
			v.corner_first = first[16:0];
			v.corner_second = 17'(first + s + 1);
			v.corner_first_next = 17'(first + 1);
			v.corner_second_next = 17'(first + s + 2);
		end
		return v;
	endfunction

	// Drive one point and record its vertex at acceptance; valid stays up afterwards
	task automatic send_point(input logic [8:0] row, input logic [8:0] col);
		while ($urandom_range(99) < pt_idle_pct) begin
			pt_valid <= 1'b0;
			@(negedge clk);
		end
		pt_valid <= 1'b1;
		pt <= '{stack_row: row, sector_col: col};
		@(posedge clk);
		while (!pt_ready)
			@(posedge clk);
		vertex_queue = {vertex_queue, vertex_of('{stack_row: row, sector_col: col})};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pt_valid <= 1'b0;
		while (vertex_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_RADIUS: radius_q = data;
			REG_SECTORS: sectors_q = data[8:0];
			REG_STACKS: stacks_q = data[8:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_sphere(input logic [15:0] r, input logic [8:0] s, input logic [8:0] t);
		wait_drained();
		write_reg(REG_RADIUS, r);
		write_reg(REG_SECTORS, {7'd0, s});
		write_reg(REG_STACKS, {7'd0, t});
		cfg_valid <= 1'b0;
	endtask

	// Poles, seams, grid edges and points just outside
	task automatic test_directed();
		send_point(9'd0, 9'd0);
		send_point(9'd18, 9'd36);
		send_point(9'd9, 9'd9);
		send_point(9'd19, 9'd0);
		send_point(9'd0, 9'd37);
		send_point(9'd511, 9'd511);
		send_point(9'd17, 9'd35);
		send_point(9'd18, 9'd0);
		send_point(9'd0, 9'd36);
		// Largest radius saturates at the equator
		set_sphere(16'hFFFF, 9'd256, 9'd256);
		send_point(9'd128, 9'd0);
		send_point(9'd128, 9'd128);
		send_point(9'd128, 9'd64);
		send_point(9'd256, 9'd256);
		send_point(9'd255, 9'd255);
		send_point(9'd0, 9'd192);
		// Count of zero acts as one; count above maximum clamps
		set_sphere(16'd0, 9'd0, 9'd0);
		send_point(9'd0, 9'd0);
		send_point(9'd1, 9'd1);
		set_sphere(16'h1234, 9'd511, 9'd300);
		send_point(9'd256, 9'd256);
		send_point(9'd257, 9'd3);
		send_point(9'd100, 9'd200);
		set_sphere(16'd256, 9'd3, 9'd2);
		send_point(9'd1, 9'd1);
		send_point(9'd2, 9'd3);
		send_point(9'd3, 9'd4);
	endtask

	// Random points on random spheres, mostly inside the grid
	task automatic test_random(input int n);
		logic [8:0] s, t, row, col;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(3))
					0: set_sphere(16'($urandom), 9'($urandom_range(3, 12)), 9'($urandom_range(2, 10)));
					1: set_sphere(16'($urandom), 9'($urandom), 9'($urandom));
					2: set_sphere(16'hFFFF, 9'd256, 9'd256);
					default: set_sphere(16'($urandom_range(0, 1024)), 9'($urandom_range(3, 64)),
						9'($urandom_range(2, 64)));
				endcase
			end
			s = (sectors_q == 0) ? 9'd1 : (sectors_q > 256) ? 9'd256 : sectors_q;
			t = (stacks_q == 0) ? 9'd1 : (stacks_q > 256) ? 9'd256 : stacks_q;
			if ($urandom_range(9) < 8) begin
				row = 9'($urandom_range(0, t));
				col = 9'($urandom_range(0, s));
			end else begin
				row = 9'($urandom);
				col = 9'($urandom);
			end
			send_point(row, col);
		end
	endtask

	// Stall input until every vertex has drained, then resume
	task automatic test_pause();
		send_point(9'd3, 9'd4);
		send_point(9'd5, 9'd6);
		pt_valid <= 1'b0;
		while (vertex_queue.size() != 0)
			@(negedge clk);
		send_point(9'd1, 9'd2);
	endtask

	// Receiver backpressure
	always @(negedge clk)
		vtx_ready <= ($urandom_range(99) >= vtx_idle_pct);

	// Compare each accepted vertex with the oldest prediction
	always @(posedge clk) begin
		vtx_t exp_v;
		if (arst_n && vtx_valid && vtx_ready) begin
			if (vertex_queue.size() == 0) begin
				$error("unexpected vertex word %h", vtx);
				errors++;
			end else begin
				exp_v = vertex_queue.pop_front();
				if (vtx.pos_x !== exp_v.pos_x) begin
					$error("pos_x exp %0d got %0d", exp_v.pos_x, vtx.pos_x); errors++; end
				if (vtx.pos_y !== exp_v.pos_y) begin
					$error("pos_y exp %0d got %0d", exp_v.pos_y, vtx.pos_y); errors++; end
				if (vtx.pos_z !== exp_v.pos_z) begin
					$error("pos_z exp %0d got %0d", exp_v.pos_z, vtx.pos_z); errors++; end
				if (vtx.tex_u !== exp_v.tex_u) begin
					$error("tex_u exp %0d got %0d", exp_v.tex_u, vtx.tex_u); errors++; end
				if (vtx.tex_v !== exp_v.tex_v) begin
					$error("tex_v exp %0d got %0d", exp_v.tex_v, vtx.tex_v); errors++; end
				if (vtx.parity !== exp_v.parity) begin
					$error("parity exp %0d got %0d", exp_v.parity, vtx.parity); errors++; end
				if (vtx.in_range !== exp_v.in_range) begin
					$error("in_range exp %0d got %0d", exp_v.in_range, vtx.in_range); errors++; end
				if (vtx.cell_valid !== exp_v.cell_valid) begin
					$error("cell_valid exp %0d got %0d", exp_v.cell_valid, vtx.cell_valid);
					errors++;
				end
				if (vtx.corner_first !== exp_v.corner_first) begin
					$error("corner_first exp %0d got %0d", exp_v.corner_first, vtx.corner_first);
					errors++;
				end
				if (vtx.corner_second !== exp_v.corner_second) begin
					$error("corner_second exp %0d got %0d", exp_v.corner_second,
						vtx.corner_second);
					errors++;
				end
				if (vtx.corner_first_next !== exp_v.corner_first_next) begin
					$error("corner_first_next exp %0d got %0d", exp_v.corner_first_next,
						vtx.corner_first_next);
					errors++;
				end
				if (vtx.corner_second_next !== exp_v.corner_second_next) begin
					$error("corner_second_next exp %0d got %0d", exp_v.corner_second_next,
						vtx.corner_second_next);
					errors++;
				end
			end
		end
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		pt_valid = 1'b0;
		pt = '0;
		vtx_ready = 1'b0;
		radius_q = RADIUS_RST;
		sectors_q = SECTORS_RST;
		stacks_q = STACKS_RST;
		pt_idle_pct = 27;
		vtx_idle_pct = 60;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(450);
		test_pause();
		pt_idle_pct = 60;
		vtx_idle_pct = 27;
		test_random(450);
		pt_idle_pct = 0;
		vtx_idle_pct = 0;
		test_random(500);
		wait_drained();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
